[rtl/core/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants for the bitmap page frame allocator: geometry of
// the block bitmap, operation codes and the command/response bundle between
// the top level and the bitmap engine.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // Block geometry
  localparam int MAX_BLOCKS  = 32768;
  localparam int BLOCK_SHIFT = 12;
  localparam int KB_SHIFT    = BLOCK_SHIFT - 10;

  // Bitmap memory geometry
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = MAX_BLOCKS / WORD_W;
  localparam int WA_W      = $clog2(NUM_WORDS);
  localparam int SW_W      = WA_W + 1;
  localparam int BLK_W     = $clog2(MAX_BLOCKS);

  // Field widths
  localparam int KB_W    = 18;
  localparam int FUNC_W  = 3;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 32;
  localparam int BIDX_W  = ADDR_W - BLOCK_SHIFT;
  localparam int CNT_W   = 16;
  localparam int BADDR_W = 27;

  // Stream word widths
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 64;
  localparam int M_PAD_W   = M_TDATA_W - (1 + BADDR_W + CNT_W + CNT_W);

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT    = 3'd0,
    FUNC_ALLOC   = 3'd1,
    FUNC_FREE    = 3'd2,
    FUNC_RELEASE = 3'd3,
    FUNC_RESERVE = 3'd4
  } func_t;

  // Bitmap engine operations
  typedef enum logic [1:0] {
    OP_FILL,
    OP_SCAN,
    OP_CLEAR,
    OP_SET
  } bm_op_t;

  // Top level sequencer states
  typedef enum logic [2:0] {
    T_IDLE,
    T_SETUP,
    T_RUN,
    T_FINISH,
    T_OUT
  } top_state_t;

  // Bitmap engine states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_REGION,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic             start;
    bm_op_t           op;
    logic             remark;     // set block 0 after the region pass
    logic             range_en;   // region holds at least one block
    logic [BLK_W-1:0] lo_blk;     // first block of the region
    logic [BLK_W-1:0] last_blk;   // last block of the region, inclusive
    logic [SW_W-1:0]  scan_words; // whole words to search, at least one
  } bm_cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [BLK_W-1:0] blk;
  } bm_rsp_t;

endpackage

[rtl/core/bpfa_bitmap.sv]
// ----------------------------------------------------------------------------
// bpfa_bitmap
// Block bitmap memory and its word sequencer: fill with ones, search for the
// lowest clear bit, set or clear a block range word by word, and re-mark
// block 0. Reads are pipelined one word per cycle; a returned word that is
// modified is written back in the cycle its data arrives.
// ----------------------------------------------------------------------------
module bpfa_bitmap (
  input  logic              clk,
  input  logic              rst,
  input  bpfa_pkg::bm_cmd_t cmd,
  output bpfa_pkg::bm_rsp_t rsp
);

  bpfa_pkg::eng_state_t state;
  bpfa_pkg::eng_state_t state_next;

  bpfa_pkg::bm_op_t                op;
  logic                            remark;
  logic [bpfa_pkg::BLK_W-1:0]      lo_blk;
  logic [bpfa_pkg::BLK_W-1:0]      last_blk;
  logic [bpfa_pkg::WA_W-1:0]       iss_wa;
  logic [bpfa_pkg::WA_W-1:0]       end_wa;
  logic [bpfa_pkg::WA_W-1:0]       q_wa;
  logic                            iss_on;
  logic                            q_on;
  logic                            found;
  logic [bpfa_pkg::BLK_W-1:0]      found_blk;

  logic [bpfa_pkg::WORD_W-1:0]     mem [bpfa_pkg::NUM_WORDS];
  logic [bpfa_pkg::WORD_W-1:0]     mem_q;
  logic                            mem_we;
  logic                            mem_re;
  logic [bpfa_pkg::WA_W-1:0]       mem_wa;
  logic [bpfa_pkg::WA_W-1:0]       mem_ra;
  logic [bpfa_pkg::WORD_W-1:0]     mem_wd;

  logic                            q_full;
  logic [bpfa_pkg::BIT_W-1:0]      zero_pos;
  logic [bpfa_pkg::WORD_W-1:0]     zero_bit;
  logic [bpfa_pkg::BIT_W-1:0]      lo_bit;
  logic [bpfa_pkg::BIT_W-1:0]      hi_bit;
  logic [bpfa_pkg::WORD_W-1:0]     mask;

  // Find the lowest clear bit of the returned word
  always_comb begin
    q_full   = (mem_q == '1);
    zero_pos = '0;
    for (int j = bpfa_pkg::WORD_W - 1; j >= 0; j--) begin
      if (!mem_q[j]) begin
        zero_pos = bpfa_pkg::BIT_W'(j);
      end
    end
    zero_bit = bpfa_pkg::WORD_W'(1) << zero_pos;
  end

  // Build the bit mask of the region inside the returned word
  always_comb begin
    lo_bit = (q_wa == lo_blk[bpfa_pkg::BLK_W-1:bpfa_pkg::BIT_W]) ?
             lo_blk[bpfa_pkg::BIT_W-1:0] : '0;
    hi_bit = (q_wa == last_blk[bpfa_pkg::BLK_W-1:bpfa_pkg::BIT_W]) ?
             last_blk[bpfa_pkg::BIT_W-1:0] : '1;
    mask   = ({bpfa_pkg::WORD_W{1'b1}} << lo_bit) &
             ({bpfa_pkg::WORD_W{1'b1}} >> (~hi_bit));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bpfa_pkg::ST_IDLE: begin
        if (cmd.start) begin
          case (cmd.op)
            bpfa_pkg::OP_FILL: state_next = bpfa_pkg::ST_FILL;
            bpfa_pkg::OP_SCAN: state_next = bpfa_pkg::ST_SCAN;
            default: begin
              if (cmd.range_en) begin
                state_next = bpfa_pkg::ST_REGION;
              end else if (cmd.remark) begin
                state_next = bpfa_pkg::ST_MARK_RD;
              end else begin
                state_next = bpfa_pkg::ST_DONE;
              end
            end
          endcase
        end
      end
      bpfa_pkg::ST_FILL: begin
        if (iss_wa == bpfa_pkg::WA_W'(bpfa_pkg::NUM_WORDS - 1)) begin
          state_next = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_SCAN: begin
        if (q_on && (!q_full || (q_wa == end_wa))) begin
          state_next = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_REGION: begin
        if (q_on && (q_wa == end_wa)) begin
          state_next = remark ? bpfa_pkg::ST_MARK_RD : bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_MARK_RD: state_next = bpfa_pkg::ST_MARK_WR;
      bpfa_pkg::ST_MARK_WR: state_next = bpfa_pkg::ST_DONE;
      bpfa_pkg::ST_DONE:    state_next = bpfa_pkg::ST_IDLE;
      default:              state_next = bpfa_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and response
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = q_wa;
    mem_ra = iss_wa;
    mem_wd = mem_q;
    case (state)
      bpfa_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = iss_wa;
        mem_wd = '1;
      end
      bpfa_pkg::ST_SCAN: begin
        mem_re = iss_on;
        mem_we = q_on && !q_full;
        mem_wd = mem_q | zero_bit;
      end
      bpfa_pkg::ST_REGION: begin
        mem_re = iss_on;
        mem_we = q_on;
        mem_wd = (op == bpfa_pkg::OP_SET) ? (mem_q | mask) : (mem_q & ~mask);
      end
      bpfa_pkg::ST_MARK_RD: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      bpfa_pkg::ST_MARK_WR: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = mem_q | bpfa_pkg::WORD_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    rsp.done  = (state == bpfa_pkg::ST_DONE);
    rsp.found = found;
    rsp.blk   = found_blk;
  end

  // Bitmap storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bpfa_pkg::ST_IDLE;
      iss_on <= 1'b0;
      q_on   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        bpfa_pkg::ST_IDLE: begin
          iss_on <= (state_next == bpfa_pkg::ST_SCAN) ||
                    (state_next == bpfa_pkg::ST_REGION);
          q_on   <= 1'b0;
        end
        bpfa_pkg::ST_SCAN, bpfa_pkg::ST_REGION: begin
          q_on <= iss_on && (state_next == state);
          if (state_next != state) begin
            iss_on <= 1'b0;
          end else if (iss_on && (iss_wa == end_wa)) begin
            iss_on <= 1'b0;
          end
        end
        default: begin
          iss_on <= 1'b0;
          q_on   <= 1'b0;
        end
      endcase
    end
  end

  // Word pointers and search result
  always_ff @(posedge clk) begin
    case (state)
      bpfa_pkg::ST_IDLE: begin
        if (cmd.start) begin
          op       <= cmd.op;
          remark   <= cmd.remark;
          lo_blk   <= cmd.lo_blk;
          last_blk <= cmd.last_blk;
          found    <= 1'b0;
          if ((cmd.op == bpfa_pkg::OP_FILL) || (cmd.op == bpfa_pkg::OP_SCAN)) begin
            iss_wa <= '0;
          end else begin
            iss_wa <= cmd.lo_blk[bpfa_pkg::BLK_W-1:bpfa_pkg::BIT_W];
          end
          if (cmd.op == bpfa_pkg::OP_SCAN) begin
            end_wa <= bpfa_pkg::WA_W'(cmd.scan_words - 1'b1);
          end else begin
            end_wa <= cmd.last_blk[bpfa_pkg::BLK_W-1:bpfa_pkg::BIT_W];
          end
        end
      end
      bpfa_pkg::ST_FILL: begin
        iss_wa <= iss_wa + 1'b1;
      end
      bpfa_pkg::ST_SCAN, bpfa_pkg::ST_REGION: begin
        q_wa <= iss_wa;
        if (iss_on && (iss_wa != end_wa)) begin
          iss_wa <= iss_wa + 1'b1;
        end
        if ((state == bpfa_pkg::ST_SCAN) && q_on && !q_full) begin
          found     <= 1'b1;
          found_blk <= {q_wa, zero_pos};
        end
      end
      default: begin
        found <= found;
      end
    endcase
  end

endmodule

[rtl/core/bitmap_page_frame_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// Bitmap page frame allocator: one bit per block in a 1024 x 32 memory plus a
// saturating used-block counter. Takes one request word, returns one result.
// ----------------------------------------------------------------------------
// Init fills every bitmap word; alloc searches words for a clear bit; free,
// reserve and release touch the words of their clipped range, and release
// then re-marks block 0, also when no block is reached. One request at a
// time, one word a cycle on the bitmap port; the next request is taken while
// the result waits downstream.
// Reset clears the counter, memory size and control; the bitmap is undefined until init.
module bitmap_page_frame_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpfa_pkg::KB_W-1:0]        cfg_wdata,  // memory_kb
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] func, [34:3] address, [66:35] length_bytes, [71:67] zero
  input  logic [bpfa_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] status, [27:1] block_address, [43:28] free_count,
  // [59:44] used_count_out, [63:60] zero
  output logic [bpfa_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int ADDR_LO = bpfa_pkg::FUNC_W;
  localparam int LEN_LO  = ADDR_LO + bpfa_pkg::ADDR_W;

  bpfa_pkg::top_state_t state;
  bpfa_pkg::top_state_t state_next;

  logic [bpfa_pkg::KB_W-1:0]    memory_kb;
  logic [bpfa_pkg::CNT_W-1:0]   used_count;
  logic [bpfa_pkg::CNT_W-1:0]   used_next;

  bpfa_pkg::func_t              func_r;
  logic [bpfa_pkg::BIDX_W-1:0]  lo_r;
  logic [bpfa_pkg::BIDX_W-1:0]  len_r;
  logic [bpfa_pkg::CNT_W-1:0]   n_eff_r;
  logic                         range_r;
  logic                         found_r;
  logic [bpfa_pkg::BLK_W-1:0]   blk_r;

  logic [bpfa_pkg::ADDR_W-1:0]  addr_in;
  logic [bpfa_pkg::LEN_W-1:0]   len_in;

  logic [bpfa_pkg::CNT_W-1:0]   kb_blocks;
  logic [bpfa_pkg::CNT_W-1:0]   total;
  logic [bpfa_pkg::BIDX_W-1:0]  n_blk;
  logic [bpfa_pkg::BIDX_W:0]    hi;
  logic [bpfa_pkg::BIDX_W:0]    hi_c;
  logic                         range_en;
  logic [bpfa_pkg::SW_W-1:0]    scan_words;
  logic                         alloc_ok;

  logic [bpfa_pkg::CNT_W-1:0]   delta;
  logic [bpfa_pkg::CNT_W:0]     sum;
  logic [bpfa_pkg::CNT_W-1:0]   add_sat;
  logic [bpfa_pkg::CNT_W-1:0]   sub_sat;
  logic                         out_free;

  logic                         out_status;
  logic [bpfa_pkg::BADDR_W-1:0] out_baddr;
  logic [bpfa_pkg::CNT_W-1:0]   out_free_cnt;
  logic [bpfa_pkg::CNT_W-1:0]   out_used;

  bpfa_pkg::bm_cmd_t            cmd;
  bpfa_pkg::bm_rsp_t            rsp;

  bpfa_bitmap u_bitmap (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  assign addr_in  = s_tdata[ADDR_LO +: bpfa_pkg::ADDR_W];
  assign len_in   = s_tdata[LEN_LO +: bpfa_pkg::LEN_W];
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{bpfa_pkg::M_PAD_W{1'b0}}, out_used, out_free_cnt, out_baddr, out_status};

  // Block total from memory size, capped
  always_comb begin
    kb_blocks = bpfa_pkg::CNT_W'(memory_kb >> bpfa_pkg::KB_SHIFT);
    total     = (kb_blocks > bpfa_pkg::CNT_W'(bpfa_pkg::MAX_BLOCKS)) ?
                bpfa_pkg::CNT_W'(bpfa_pkg::MAX_BLOCKS) : kb_blocks;
  end

  // Clip the request range to the block total
  always_comb begin
    n_blk      = (func_r == bpfa_pkg::FUNC_FREE) ? bpfa_pkg::BIDX_W'(1) : len_r;
    hi         = {1'b0, lo_r} + {1'b0, n_blk};
    hi_c       = (hi > (bpfa_pkg::BIDX_W + 1)'(total)) ?
                 (bpfa_pkg::BIDX_W + 1)'(total) : hi;
    range_en   = ({1'b0, lo_r} < hi_c);
    scan_words = bpfa_pkg::SW_W'(total >> bpfa_pkg::BIT_W);
    alloc_ok   = (used_count < total) && (scan_words != '0);
  end

  // Saturating counter update
  always_comb begin
    delta   = (func_r == bpfa_pkg::FUNC_ALLOC) ? bpfa_pkg::CNT_W'(1) : n_eff_r;
    sum     = {1'b0, used_count} + {1'b0, delta};
    add_sat = (sum > {1'b0, total}) ?
              ((used_count > total) ? used_count : total) : bpfa_pkg::CNT_W'(sum);
    sub_sat = (delta >= used_count) ? '0 : (used_count - delta);
    case (func_r)
      bpfa_pkg::FUNC_INIT:    used_next = total;
      bpfa_pkg::FUNC_ALLOC:   used_next = found_r ? add_sat : used_count;
      bpfa_pkg::FUNC_FREE,
      bpfa_pkg::FUNC_RELEASE: used_next = range_r ? sub_sat : used_count;
      bpfa_pkg::FUNC_RESERVE: used_next = range_r ? add_sat : used_count;
      default:                used_next = used_count;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bpfa_pkg::T_IDLE:   if (s_tvalid) state_next = bpfa_pkg::T_SETUP;
      bpfa_pkg::T_SETUP:  state_next = cmd.start ? bpfa_pkg::T_RUN : bpfa_pkg::T_FINISH;
      bpfa_pkg::T_RUN:    if (rsp.done) state_next = bpfa_pkg::T_FINISH;
      bpfa_pkg::T_FINISH: state_next = bpfa_pkg::T_OUT;
      bpfa_pkg::T_OUT:    if (out_free) state_next = bpfa_pkg::T_IDLE;
      default:            state_next = bpfa_pkg::T_IDLE;
    endcase
  end

  // Handshake and bitmap command
  always_comb begin
    s_tready       = (state == bpfa_pkg::T_IDLE);
    cmd.start      = 1'b0;
    cmd.op         = bpfa_pkg::OP_CLEAR;
    cmd.remark     = 1'b0;
    cmd.range_en   = range_en;
    cmd.lo_blk     = bpfa_pkg::BLK_W'(lo_r);
    cmd.last_blk   = bpfa_pkg::BLK_W'(hi_c - 1'b1);
    cmd.scan_words = scan_words;
    if (state == bpfa_pkg::T_SETUP) begin
      case (func_r)
        bpfa_pkg::FUNC_INIT: begin
          cmd.start = 1'b1;
          cmd.op    = bpfa_pkg::OP_FILL;
        end
        bpfa_pkg::FUNC_ALLOC: begin
          cmd.start = alloc_ok;
          cmd.op    = bpfa_pkg::OP_SCAN;
        end
        bpfa_pkg::FUNC_FREE: begin
          cmd.start = range_en;
          cmd.op    = bpfa_pkg::OP_CLEAR;
        end
        bpfa_pkg::FUNC_RELEASE: begin
          cmd.start  = 1'b1;
          cmd.op     = bpfa_pkg::OP_CLEAR;
          cmd.remark = 1'b1;
        end
        bpfa_pkg::FUNC_RESERVE: begin
          cmd.start = range_en;
          cmd.op    = bpfa_pkg::OP_SET;
        end
        default: begin
          cmd.start = 1'b0;
        end
      endcase
    end
  end

  // Control state, configuration, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpfa_pkg::T_IDLE;
      memory_kb  <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        memory_kb <= cfg_wdata;
      end
      if (state == bpfa_pkg::T_FINISH) begin
        used_count <= used_next;
      end
      if ((state == bpfa_pkg::T_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request fields, range bookkeeping and result word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r <= bpfa_pkg::func_t'(s_tdata[bpfa_pkg::FUNC_W-1:0]);
      lo_r   <= addr_in[bpfa_pkg::ADDR_W-1:bpfa_pkg::BLOCK_SHIFT];
      len_r  <= len_in[bpfa_pkg::LEN_W-1:bpfa_pkg::BLOCK_SHIFT];
    end
    if (state == bpfa_pkg::T_SETUP) begin
      n_eff_r <= bpfa_pkg::CNT_W'(hi_c - {1'b0, lo_r});
      range_r <= range_en;
      found_r <= 1'b0;
    end
    if ((state == bpfa_pkg::T_RUN) && rsp.done) begin
      found_r <= rsp.found;
      blk_r   <= rsp.blk;
    end
    if ((state == bpfa_pkg::T_OUT) && out_free) begin
      out_status   <= (func_r == bpfa_pkg::FUNC_ALLOC) && !found_r;
      out_baddr    <= found_r ?
                      bpfa_pkg::BADDR_W'({blk_r, {bpfa_pkg::BLOCK_SHIFT{1'b0}}}) : '0;
      out_free_cnt <= (used_count >= total) ? '0 : (total - used_count);
      out_used     <= used_count;
    end
  end

endmodule
